// File: hdl/rpt_pkg.sv
// Shared types, codes and defaults for the ready priority tracker.
package rpt_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_PRIOS_DEF = 256;
    localparam int COUNT_MAX_DEF = 255;

    // Priorities the 8-bit prio field can address
    localparam int PRIO_SPAN = 256;

    // Operation codes; code 3 behaves as a query
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] prio;
    } t_in_item;

    typedef struct packed {
        logic [7:0] top_prio;
        logic       any_ready;
        logic [1:0] status;
    } t_out_item;

    // Sequencer: update, three lookup levels, result hand-off
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_L2,
        S_L1,
        S_L0,
        S_FIN
    } t_state;

endpackage

// File: hdl/ready_priority_tracker_top.sv
// Ready priority tracker: ready counts, four-level bitmap and lowest-priority lookup.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one op and a
// priority: insert a ready task, remove one, or query only. Each item yields
// exactly one result on the output channel (o_out_valid / i_out_ready /
// o_out_item): the lowest-numbered priority with ready tasks after the
// update, an any-ready flag and a status (ok, remove from empty, count full).
// Priorities at or above NUM_PRIOS are ignored and report ok.
// The sequencer steps through a registered count read as the item is accepted,
// the count and bitmap update, then one bitmap level per state as the single
// byte priority encoder walks from the group64 byte down through group8 to the
// leaf byte, and a final step that loads the output register. A new item is
// accepted only in the idle state, so the next item waits until the current
// one has been handed to the output register.
// The output register holds the result until taken; the next item may be
// accepted meanwhile, and its result waits in the sequencer if the receiver
// still stalls. Synchronous active-low reset clears the bitmaps, and with
// them all counts; no clearing pass is needed.
module ready_priority_tracker_top #(
    parameter int NUM_PRIOS = rpt_pkg::NUM_PRIOS_DEF,
    parameter int COUNT_MAX = rpt_pkg::COUNT_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rpt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rpt_pkg::t_out_item o_out_item
);

    localparam int DEPTH = (NUM_PRIOS < rpt_pkg::PRIO_SPAN) ? NUM_PRIOS : rpt_pkg::PRIO_SPAN;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(COUNT_MAX + 1);

    rpt_pkg::t_state    r_state, n_state;
    logic [1:0]         r_op;
    logic [7:0]         r_prio;
    logic [31:0][7:0]   r_leaf, n_leaf;
    logic [3:0][7:0]    r_g8, n_g8;
    logic [7:0]         r_g64, n_g64;
    logic [7:0]         r_g512, n_g512;
    logic [1:0]         r_status, n_status;
    logic [1:0]         r_g8i, n_g8i;
    logic [4:0]         r_leafi, n_leafi;
    logic [7:0]         r_top, n_top;
    logic               r_out_valid, n_out_valid;
    rpt_pkg::t_out_item r_out, n_out;

    logic               in_acc;
    logic               out_load;
    logic [CNT_W-1:0]   rd_data;
    logic [CNT_W-1:0]   wr_data;
    logic               we;
    logic [CNT_W-1:0]   cur_cnt;
    logic               in_range;
    logic [7:0]         clr_leaf;
    logic [7:0]         clr_g8;
    logic [7:0]         clr_g64;
    logic [7:0]         ffs_in;
    logic [2:0]         ffs_idx;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = !r_out_valid || i_out_ready;

    // Count store
    rpt_cnt_mem #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_cnt_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (r_prio[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (i_in_item.prio[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared byte priority encoder
    rpt_ffs8 u_ffs (
        .i_byte (ffs_in),
        .o_idx  (ffs_idx)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpt_pkg::S_IDLE: if (i_in_valid) n_state = rpt_pkg::S_EXEC;
            rpt_pkg::S_EXEC: n_state = rpt_pkg::S_L2;
            rpt_pkg::S_L2:   n_state = rpt_pkg::S_L1;
            rpt_pkg::S_L1:   n_state = rpt_pkg::S_L0;
            rpt_pkg::S_L0:   n_state = rpt_pkg::S_FIN;
            rpt_pkg::S_FIN:  if (out_load) n_state = rpt_pkg::S_IDLE;
            default:         n_state = rpt_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: ready and encoder byte select
    always_comb begin
        o_in_ready = 1'b0;
        ffs_in     = r_g512;
        unique case (r_state)
            rpt_pkg::S_IDLE: o_in_ready = 1'b1;
            rpt_pkg::S_L2:   ffs_in = r_g64;
            rpt_pkg::S_L1:   ffs_in = r_g8[r_g8i];
            rpt_pkg::S_L0:   ffs_in = r_leaf[r_leafi];
            default:         ffs_in = r_g512;
        endcase
    end

    // Count and bitmap update; a leaf bit doubles as the count's valid bit
    assign cur_cnt  = r_leaf[r_prio[7:3]][r_prio[2:0]] ? rd_data : '0;
    assign in_range = int'(r_prio) < NUM_PRIOS;
    assign clr_leaf = r_leaf[r_prio[7:3]] & ~(8'b1 << r_prio[2:0]);
    assign clr_g8   = r_g8[r_prio[7:6]] & ~(8'b1 << r_prio[5:3]);
    assign clr_g64  = r_g64 & ~(8'b1 << {1'b0, r_prio[7:6]});

    always_comb begin
        n_leaf   = r_leaf;
        n_g8     = r_g8;
        n_g64    = r_g64;
        n_g512   = r_g512;
        n_status = r_status;
        we       = 1'b0;
        wr_data  = cur_cnt;
        if (r_state == rpt_pkg::S_EXEC) begin
            n_status = rpt_pkg::ST_OK;
            if (in_range && r_op == rpt_pkg::OP_INSERT) begin
                if (cur_cnt == CNT_W'(COUNT_MAX)) begin
                    n_status = rpt_pkg::ST_FULL;
                end else begin
                    we      = 1'b1;
                    wr_data = cur_cnt + CNT_W'(1);
                    n_leaf[r_prio[7:3]][r_prio[2:0]] = 1'b1;
                    n_g8[r_prio[7:6]][r_prio[5:3]]   = 1'b1;
                    n_g64[{1'b0, r_prio[7:6]}]        = 1'b1;
                    n_g512[0]                         = 1'b1;
                end
            end else if (in_range && r_op == rpt_pkg::OP_REMOVE) begin
                if (cur_cnt == '0) begin
                    n_status = rpt_pkg::ST_EMPTY;
                end else begin
                    we      = 1'b1;
                    wr_data = cur_cnt - CNT_W'(1);
                    // Last task gone: clear upward while bytes empty out
                    if (cur_cnt == CNT_W'(1)) begin
                        n_leaf[r_prio[7:3]] = clr_leaf;
                        if (clr_leaf == 8'd0) begin
                            n_g8[r_prio[7:6]] = clr_g8;
                            if (clr_g8 == 8'd0) begin
                                n_g64 = clr_g64;
                                if (clr_g64 == 8'd0) begin
                                    n_g512 = r_g512 & ~8'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // Lookup index accumulation, one level per cycle
    always_comb begin
        n_g8i   = r_g8i;
        n_leafi = r_leafi;
        n_top   = r_top;
        unique case (r_state)
            rpt_pkg::S_L2: n_g8i   = ffs_idx[1:0];
            rpt_pkg::S_L1: n_leafi = {r_g8i, ffs_idx};
            rpt_pkg::S_L0: n_top   = {r_leafi, ffs_idx};
            default:       n_top   = r_top;
        endcase
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (r_state == rpt_pkg::S_FIN && out_load) begin
            n_out_valid     = 1'b1;
            n_out.any_ready = |r_g512;
            n_out.top_prio  = (|r_g512) ? r_top : 8'd0;
            n_out.status    = r_status;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_leaf      <= '0;
            r_g8        <= '0;
            r_g64       <= '0;
            r_g512      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_leaf      <= n_leaf;
            r_g8        <= n_g8;
            r_g64       <= n_g64;
            r_g512      <= n_g512;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in_item.op;
            r_prio <= i_in_item.prio;
        end
        r_status <= n_status;
        r_g8i    <= n_g8i;
        r_leafi  <= n_leafi;
        r_top    <= n_top;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Summary levels mirror whether their children are non-empty
    a_g512_summary : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g512[0] == (r_g64 != 8'd0))
        else $error("group512 bit out of step with group64 byte");

    a_g64_summary : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g64[3:0] == {|r_g8[3], |r_g8[2], |r_g8[1], |r_g8[0]})
        else $error("group64 bits out of step with group8 bytes");

    // Nothing ready must report priority zero
    a_idle_top : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.any_ready |-> o_out_item.top_prio == 8'd0)
        else $error("top priority non-zero with nothing ready");

    // An accepted item starts the update in the next cycle
    a_accept_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == rpt_pkg::S_EXEC)
        else $error("accepted item did not start update");

    // Bitmaps change only during the update step
    a_bitmap_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != rpt_pkg::S_EXEC |=> $stable(r_leaf) && $stable(r_g8))
        else $error("bitmap changed outside update step");

endmodule

// File: hdl/rpt_ffs8.sv
// Shared lowest-set-bit finder over one bitmap byte.
module rpt_ffs8 (
    input  logic [7:0] i_byte,
    output logic [2:0] o_idx
);

    // Highest bit first so the lowest set bit wins; zero byte gives index 0
    always_comb begin
        o_idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (i_byte[i]) begin
                o_idx = 3'(i);
            end
        end
    end

endmodule

// File: hdl/rpt_cnt_mem.sv
// Per-priority ready count store, one write and one registered read port.
module rpt_cnt_mem #(
    parameter int DEPTH = rpt_pkg::PRIO_SPAN,
    parameter int CNT_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [CNT_W-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [CNT_W-1:0]         o_rd_data
);

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rd_data;

    // Contents need no reset: a clear leaf bit marks the count as zero
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
